// ===== rtl/pip_pkg.sv =====
// Shared types, codes and constants of the palette image placer.
// Used by every module of the block; depends on nothing.
`timescale 1ns / 1ps

package pip_pkg;

    localparam int MAX_DIM           = 4096;
    localparam int PALETTE_DEPTH_DEF = 256;
    localparam int QDEPTH            = 4;
    localparam int QCNT_W            = $clog2(QDEPTH + 1);
    localparam int CFG_IDX_W         = 3;
    localparam int CFG_DATA_W        = 13;
    localparam int TOTAL_W           = 26;

    localparam logic [7:0] ALPHA_OPAQUE = 8'd255;

    localparam logic CMD_PALETTE = 1'b0;
    localparam logic CMD_PIXEL   = 1'b1;

    localparam logic ORDER_ROW = 1'b0;

    localparam logic [CFG_IDX_W-1:0] CFG_CANVAS_W  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CANVAS_H  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_W   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_H   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_X  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_Y  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_ORDER     = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_PAL_COUNT = 3'd7;

    typedef enum logic [2:0] {
        ERR_NONE     = 3'd0,
        ERR_ZERO_DIM = 3'd1,
        ERR_CANVAS   = 3'd2,
        ERR_INDEX    = 3'd3,
        ERR_COUNT    = 3'd4
    } t_pip_err;

    typedef struct packed {
        logic [12:0] canvas_width;
        logic [12:0] canvas_height;
        logic [12:0] image_width;
        logic [12:0] image_height;
        logic [11:0] offset_x;
        logic [11:0] offset_y;
        logic        pixel_order;
        logic [8:0]  palette_count;
    } t_pip_cfg;

    typedef struct packed {
        logic       cmd;
        logic [7:0] entry_index;
        logic [7:0] entry_red;
        logic [7:0] entry_green;
        logic [7:0] entry_blue;
        logic [7:0] pixel_palette_index;
        logic       pixel_last;
    } t_pip_in;

    typedef struct packed {
        logic [23:0] canvas_index;
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
        logic [7:0]  alpha;
        logic        write_pixel;
        logic [23:0] source_index;
        logic [7:0]  source_palette_index;
        logic [2:0]  error;
    } t_pip_out;

    // One classified item on its way from the front to the back.
    typedef struct packed {
        logic        is_pixel;
        logic [7:0]  index;
        logic [23:0] rgb;
        logic [11:0] row;
        logic [11:0] col;
        logic [23:0] pos;
        t_pip_err    err;
    } t_pip_job;

endpackage

// ===== rtl/pip_fifo.sv =====
// Small synchronous queue of registers, used between front and back and at the output.
// Depends on pip_pkg for the default depth.
`timescale 1ns / 1ps

module pip_fifo #(
    parameter type T     = logic,
    parameter int  DEPTH = pip_pkg::QDEPTH
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_push,
    input  T                             i_data,
    input  logic                         i_pop,
    output T                             o_data,
    output logic [$clog2(DEPTH+1)-1:0]   o_count
);
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    T                 r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr;
    logic [PTR_W-1:0] r_rd;
    logic [CNT_W-1:0] r_count;
    logic [PTR_W-1:0] n_wr;
    logic [PTR_W-1:0] n_rd;
    logic [CNT_W-1:0] n_count;

    always_comb begin
        n_wr    = r_wr;
        n_rd    = r_rd;
        n_count = r_count;
        if (i_push) begin
            n_wr = (r_wr == PTR_W'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
        end
        if (i_pop) begin
            n_rd = (r_rd == PTR_W'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
        end
        case ({i_push, i_pop})
            2'b10:   n_count = r_count + 1'b1;
            2'b01:   n_count = r_count - 1'b1;
            default: n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    assign o_data  = r_mem[r_rd];
    assign o_count = r_count;

endmodule

// ===== rtl/pip_front.sv =====
// Front end: keeps the image position counters and classifies each accepted item.
// Depends on pip_pkg; feeds the job queue read by pip_back.
`timescale 1ns / 1ps

module pip_front #(
    parameter int PALETTE_DEPTH = pip_pkg::PALETTE_DEPTH_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  pip_pkg::t_pip_cfg  i_cfg,
    input  logic               i_accept,
    input  pip_pkg::t_pip_in   i_item,
    output pip_pkg::t_pip_job  o_job
);
    import pip_pkg::*;

    localparam logic [14:0] MAX_DIM_W = 15'(MAX_DIM);
    localparam logic [8:0]  PAL_DEPTH = 9'(PALETTE_DEPTH);

    logic [11:0]        r_col;
    logic [11:0]        r_row;
    logic [23:0]        r_pos;
    logic [TOTAL_W-1:0] r_total;
    logic [11:0]        n_col;
    logic [11:0]        n_row;
    logic [23:0]        n_pos;

    logic       w_zero;
    logic       w_big;
    logic       w_count;
    logic       w_bad;
    logic [8:0] w_pcount;
    t_pip_err   w_err;

    always_comb begin
        w_zero = (i_cfg.canvas_width == '0) || (i_cfg.canvas_height == '0) ||
                 (i_cfg.image_width == '0) || (i_cfg.image_height == '0);
        w_big  = (15'(i_cfg.canvas_width) > MAX_DIM_W) ||
                 (15'(i_cfg.canvas_height) > MAX_DIM_W) ||
                 (15'(i_cfg.image_width) > MAX_DIM_W) ||
                 (15'(i_cfg.image_height) > MAX_DIM_W) ||
                 ((14'(i_cfg.offset_x) + 14'(i_cfg.image_width)) >
                  14'(i_cfg.canvas_width)) ||
                 ((14'(i_cfg.offset_y) + 14'(i_cfg.image_height)) >
                  14'(i_cfg.canvas_height));
        w_count = (TOTAL_W'(r_pos) >= r_total) ||
                  (i_item.pixel_last && ((TOTAL_W'(r_pos) + 1'b1) != r_total));
        w_pcount = (i_cfg.palette_count > PAL_DEPTH) ? PAL_DEPTH : i_cfg.palette_count;
        w_bad    = {1'b0, i_item.pixel_palette_index} >= w_pcount;
        if (w_zero) begin
            w_err = ERR_ZERO_DIM;
        end else if (w_big) begin
            w_err = ERR_CANVAS;
        end else if (w_count) begin
            w_err = ERR_COUNT;
        end else if (w_bad) begin
            w_err = ERR_INDEX;
        end else begin
            w_err = ERR_NONE;
        end
    end

    always_comb begin
        o_job.is_pixel = (i_item.cmd == CMD_PIXEL);
        o_job.index    = (i_item.cmd == CMD_PIXEL) ? i_item.pixel_palette_index
                                                   : i_item.entry_index;
        o_job.rgb      = {i_item.entry_red, i_item.entry_green, i_item.entry_blue};
        o_job.row      = r_row;
        o_job.col      = r_col;
        o_job.pos      = r_pos;
        o_job.err      = w_err;
    end

    always_comb begin
        n_col = r_col;
        n_row = r_row;
        n_pos = r_pos;
        if (i_accept && (i_item.cmd == CMD_PIXEL)) begin
            if (i_item.pixel_last) begin
                n_col = '0;
                n_row = '0;
                n_pos = '0;
            end else begin
                n_pos = r_pos + 1'b1;
                if (i_cfg.pixel_order == ORDER_ROW) begin
                    if ((13'(r_col) + 1'b1) >= i_cfg.image_width) begin
                        n_col = '0;
                        n_row = r_row + 1'b1;
                    end else begin
                        n_col = r_col + 1'b1;
                    end
                end else begin
                    if ((13'(r_row) + 1'b1) >= i_cfg.image_height) begin
                        n_row = '0;
                        n_col = r_col + 1'b1;
                    end else begin
                        n_row = r_row + 1'b1;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col   <= '0;
            r_row   <= '0;
            r_pos   <= '0;
            r_total <= '0;
        end else begin
            r_col   <= n_col;
            r_row   <= n_row;
            r_pos   <= n_pos;
            r_total <= TOTAL_W'(i_cfg.image_width) * TOTAL_W'(i_cfg.image_height);
        end
    end

endmodule

// ===== rtl/pip_back.sv =====
// Back end: palette memory, canvas position arithmetic and result assembly.
// Depends on pip_pkg; reads the job queue and writes the result queue.
`timescale 1ns / 1ps

module pip_back #(
    parameter int PALETTE_DEPTH = pip_pkg::PALETTE_DEPTH_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  pip_pkg::t_pip_cfg           i_cfg,
    input  logic [pip_pkg::QCNT_W-1:0]  i_job_count,
    input  pip_pkg::t_pip_job           i_job,
    output logic                        o_job_pop,
    input  logic [pip_pkg::QCNT_W-1:0]  i_out_count,
    output logic                        o_out_push,
    output pip_pkg::t_pip_out           o_out_item
);
    import pip_pkg::*;

    localparam int PW = $clog2(PALETTE_DEPTH);

    logic [23:0]        r_pal [PALETTE_DEPTH];
    logic [23:0]        r_rgb;
    logic               r_s1_valid;
    logic [TOTAL_W-1:0] r_rowbase;
    logic [12:0]        r_colsum;
    logic [23:0]        r_pos;
    logic [7:0]         r_pidx;
    t_pip_err           r_err;

    logic               w_pop;
    logic               w_write;
    logic [12:0]        w_rowsum;
    logic [TOTAL_W-1:0] w_index;

    // Room is counted with the item already in the stage register.
    assign w_pop = (i_job_count != '0) &&
                   ((i_out_count + QCNT_W'(r_s1_valid)) < QCNT_W'(QDEPTH));
    assign o_job_pop = w_pop;
    assign w_rowsum  = 13'(i_cfg.offset_y) + 13'(i_job.row);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else begin
            r_s1_valid <= w_pop && i_job.is_pixel;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_pop) begin
            r_rowbase <= TOTAL_W'(w_rowsum) * TOTAL_W'(i_cfg.canvas_width);
            r_colsum  <= 13'(i_cfg.offset_x) + 13'(i_job.col);
            r_pos     <= i_job.pos;
            r_pidx    <= i_job.index;
            r_err     <= i_job.err;
            r_rgb     <= r_pal[i_job.index[PW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_pop && !i_job.is_pixel && ({1'b0, i_job.index} < 9'(PALETTE_DEPTH))) begin
            r_pal[i_job.index[PW-1:0]] <= i_job.rgb;
        end
    end

    assign w_write = (r_err == ERR_NONE) && (r_pidx != '0);
    assign w_index = r_rowbase + TOTAL_W'(r_colsum);

    always_comb begin
        o_out_push                      = r_s1_valid;
        o_out_item.canvas_index         = w_index[23:0];
        o_out_item.red                  = w_write ? r_rgb[23:16] : 8'd0;
        o_out_item.green                = w_write ? r_rgb[15:8] : 8'd0;
        o_out_item.blue                 = w_write ? r_rgb[7:0] : 8'd0;
        o_out_item.alpha                = w_write ? ALPHA_OPAQUE : 8'd0;
        o_out_item.write_pixel          = w_write;
        o_out_item.source_index         = r_pos;
        o_out_item.source_palette_index = r_pidx;
        o_out_item.error                = r_err;
    end

endmodule

// ===== rtl/palette_image_placer_core.sv =====
// Top level of the palette image placer: configuration registers, queues and the two halves.
// Depends on pip_pkg, pip_fifo, pip_front and pip_back.
//
// Input items enter through push/full; cmd 0 loads a palette entry, cmd 1 delivers a pixel.
// Every pixel item gives one result on o_out_item, read through empty/pop; palette writes
// give none. Results come out in order, through the job queue, back stage and result queue.
// One item is taken per cycle while full is low; the rate is set by the combinational front
// classifier and the one-stage back pipeline, whose 13x13 canvas multiply is registered
// before the final add. A four-entry job queue parts front and back, and a four-entry result
// queue parts the back from the receiver. When pop stays low the result queue fills, the back
// stops draining the job queue, and full rises once that queue is full too; nothing is dropped.
// Configuration writes (i_cfg_valid/o_cfg_ready) are always taken; full is held high for the
// cycle after a write while the image size product settles.
// Reset clears the configuration, the counters and both queues. The palette memory is not
// cleared and must be loaded before its entries are used.
`timescale 1ns / 1ps

module palette_image_placer_core #(
    parameter int PALETTE_DEPTH = pip_pkg::PALETTE_DEPTH_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              push,
    output logic                              full,
    input  pip_pkg::t_pip_in                  i_in_item,
    output logic                              empty,
    input  logic                              pop,
    output pip_pkg::t_pip_out                 o_out_item,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [pip_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [pip_pkg::CFG_DATA_W-1:0]    i_cfg_data
);
    import pip_pkg::*;

    t_pip_cfg            r_cfg;
    logic                r_cfg_hold;
    logic                w_cfg_we;
    logic                w_accept;
    t_pip_job            w_job_in;
    t_pip_job            w_job_out;
    logic [QCNT_W-1:0]   w_job_count;
    logic                w_job_pop;
    logic                w_job_full;
    t_pip_out            w_res_in;
    logic                w_res_push;
    logic [QCNT_W-1:0]   w_res_count;
    logic                w_res_pop;

    assign o_cfg_ready = 1'b1;
    assign w_cfg_we    = i_cfg_valid && o_cfg_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg      <= '0;
            r_cfg_hold <= 1'b0;
        end else begin
            r_cfg_hold <= w_cfg_we;
            if (w_cfg_we) begin
                case (i_cfg_index)
                    CFG_CANVAS_W:  r_cfg.canvas_width  <= i_cfg_data;
                    CFG_CANVAS_H:  r_cfg.canvas_height <= i_cfg_data;
                    CFG_IMAGE_W:   r_cfg.image_width   <= i_cfg_data;
                    CFG_IMAGE_H:   r_cfg.image_height  <= i_cfg_data;
                    CFG_OFFSET_X:  r_cfg.offset_x      <= i_cfg_data[11:0];
                    CFG_OFFSET_Y:  r_cfg.offset_y      <= i_cfg_data[11:0];
                    CFG_ORDER:     r_cfg.pixel_order   <= i_cfg_data[0];
                    CFG_PAL_COUNT: r_cfg.palette_count <= i_cfg_data[8:0];
                    default: begin
                    end
                endcase
            end
        end
    end

    assign w_job_full = (w_job_count == QCNT_W'(QDEPTH));
    assign full       = w_job_full || r_cfg_hold;
    assign w_accept   = push && !full;

    pip_front #(
        .PALETTE_DEPTH (PALETTE_DEPTH)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (r_cfg),
        .i_accept (w_accept),
        .i_item   (i_in_item),
        .o_job    (w_job_in)
    );

    pip_fifo #(
        .T     (t_pip_job),
        .DEPTH (QDEPTH)
    ) u_job_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_accept),
        .i_data  (w_job_in),
        .i_pop   (w_job_pop),
        .o_data  (w_job_out),
        .o_count (w_job_count)
    );

    pip_back #(
        .PALETTE_DEPTH (PALETTE_DEPTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_job_count (w_job_count),
        .i_job       (w_job_out),
        .o_job_pop   (w_job_pop),
        .i_out_count (w_res_count),
        .o_out_push  (w_res_push),
        .o_out_item  (w_res_in)
    );

    assign empty     = (w_res_count == '0);
    assign w_res_pop = pop && !empty;

    pip_fifo #(
        .T     (t_pip_out),
        .DEPTH (QDEPTH)
    ) u_res_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_res_push),
        .i_data  (w_res_in),
        .i_pop   (w_res_pop),
        .o_data  (o_out_item),
        .o_count (w_res_count)
    );

`ifndef ASSERT_OFF
    a_res_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_res_push |-> (w_res_count != QCNT_W'(QDEPTH)) || w_res_pop)
        else $error("result queue written while full");

    a_job_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_job_pop |-> (w_job_count != '0))
        else $error("job queue read while empty");

    a_cfg_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cfg_we |=> full)
        else $error("input taken right after a configuration write");

    a_written_opaque: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_out_item.write_pixel) |->
            (o_out_item.alpha == ALPHA_OPAQUE) && (o_out_item.error == ERR_NONE))
        else $error("written pixel without full alpha or with an error");
`endif

endmodule
